### rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, operation codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WordBits = 32;
  localparam int CntBits  = 6;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_NRM = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               overflow;
  } rau_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_GCD_WAIT,
    ST_QN_DIV,
    ST_QN_WAIT,
    ST_QD_DIV,
    ST_QD_WAIT,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_SUM,
    CMD_GCD_START,
    CMD_GCD_STEP,
    CMD_QN_START,
    CMD_QN_TAKE,
    CMD_QD_START,
    CMD_QD_TAKE,
    CMD_FIX
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } rau_ctl_t;

  typedef struct packed {
    logic y_zero;
    logic g_zero;
    logic div_done;
    logic mul_path;
  } rau_sts_t;

endpackage

### rtl/rau_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring signed divider, one quotient bit per cycle, truncating result.
// ----------------------------------------------------------------------------
module rau_divider
  import rau_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [WordBits-1:0] dividend,
  input  logic signed [WordBits-1:0] divisor,
  output logic                       done,
  output logic signed [WordBits-1:0] quot,
  output logic signed [WordBits-1:0] rem
);

  logic [WordBits-1:0] dvd;
  logic [WordBits-1:0] dvs;
  logic [WordBits:0]   part;
  logic [WordBits-1:0] q;
  logic                neg_q;
  logic                neg_r;
  logic                run;
  logic [CntBits-1:0]  cnt;
  logic [WordBits:0]   shifted;
  logic [WordBits:0]   trial;

  assign shifted = {part[WordBits-1:0], dvd[WordBits-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CntBits'(WordBits);
        dvd   <= dividend[WordBits-1] ? WordBits'(-dividend) : dividend;
        dvs   <= divisor[WordBits-1] ? WordBits'(-divisor) : divisor;
        neg_q <= dividend[WordBits-1] ^ divisor[WordBits-1];
        neg_r <= dividend[WordBits-1];
        part  <= '0;
        q     <= '0;
      end else if (run) begin
        dvd <= {dvd[WordBits-2:0], 1'b0};
        if (!trial[WordBits]) begin
          part <= trial;
          q    <= {q[WordBits-2:0], 1'b1};
        end else begin
          part <= shifted;
          q    <= {q[WordBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg_q ? WordBits'(-q) : q;
  assign rem  = neg_r ? WordBits'(-part[WordBits-1:0]) : part[WordBits-1:0];

endmodule

### rtl/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Cross products, Euclid loop and reduction on a shared multiplier/divider.
// ----------------------------------------------------------------------------
module rau_datapath
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rau_in_t  in_item,
  input  rau_ctl_t ctl,
  output rau_sts_t sts,
  output rau_out_t out_item
);

  localparam logic signed [WordBits-1:0] MinusOne = -1;

  logic [2:0]                 mode;
  logic signed [WordBits-1:0] an, ad, bn, bd;
  logic signed [WordBits-1:0] n, d, p, q, x, y, g;
  logic                       ov;
  logic signed [WordBits-1:0] ma, mb;
  logic signed [2*WordBits-1:0] prod;
  logic                       prod_ov;
  logic signed [WordBits:0]   sum;
  logic                       div_start;
  logic signed [WordBits-1:0] div_a, div_b, quot, rem;
  logic                       div_done;
  logic                       div_quot_ov;

  always_comb begin
    ma = an;
    mb = bd;
    case (ctl.cmd)
      CMD_MUL1: begin
        ma = an;
        mb = (mode == OP_MUL) ? bn : bd;
      end
      CMD_MUL2: begin
        ma = ad;
        mb = (mode == OP_MUL) ? bd : bn;
      end
      CMD_MUL3: begin
        ma = ad;
        mb = bd;
      end
      default: begin
        ma = an;
        mb = bd;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign prod_ov = prod != {{WordBits{prod[WordBits-1]}}, prod[WordBits-1:0]};
  assign sum     = (mode == OP_ADD) ? ({p[WordBits-1], p} + {q[WordBits-1], q})
                                    : ({p[WordBits-1], p} - {q[WordBits-1], q});

  // g is captured on the same edge, so the first reduction divides by x
  always_comb begin
    div_start = 1'b0;
    div_a     = x;
    div_b     = y;
    case (ctl.cmd)
      CMD_GCD_START: div_start = 1'b1;
      CMD_QN_START: begin
        div_start = 1'b1;
        div_a     = n;
        div_b     = x;
      end
      CMD_QD_START: begin
        div_start = 1'b1;
        div_a     = d;
        div_b     = g;
      end
      default: div_start = 1'b0;
    endcase
  end

  rau_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // quotient overflow only for most-negative / -1
  assign div_quot_ov = (g == MinusOne) &&
                       (quot == {1'b1, {(WordBits-1){1'b0}}});

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        mode <= in_item.mode;
        an   <= in_item.a_num;
        ad   <= in_item.a_den;
        bn   <= in_item.b_num;
        bd   <= in_item.b_den;
        ov   <= 1'b0;
        n    <= in_item.a_num;
        d    <= in_item.a_den;
        if (in_item.mode == OP_NEG) begin
          n  <= WordBits'(-in_item.a_num);
          ov <= in_item.a_num == {1'b1, {(WordBits-1){1'b0}}};
        end
      end
      CMD_MUL1: begin
        p  <= prod[WordBits-1:0];
        n  <= prod[WordBits-1:0];
        ov <= ov | prod_ov;
      end
      CMD_MUL2: begin
        q  <= prod[WordBits-1:0];
        d  <= prod[WordBits-1:0];
        ov <= ov | prod_ov;
      end
      CMD_MUL3: begin
        d  <= prod[WordBits-1:0];
        ov <= ov | prod_ov;
      end
      CMD_SUM: begin
        n  <= sum[WordBits-1:0];
        ov <= ov | (sum[WordBits] != sum[WordBits-1]);
      end
      CMD_GCD_START: begin
        if (x == '0 && y == '0) begin
          x <= n;
          y <= d;
        end
      end
      CMD_GCD_STEP: begin
        x <= y;
        y <= (y == MinusOne) ? '0 : rem;
      end
      CMD_QN_TAKE: begin
        n  <= quot;
        ov <= ov | div_quot_ov;
      end
      CMD_QD_TAKE: begin
        d  <= quot;
        ov <= ov | div_quot_ov;
      end
      CMD_FIX: begin
        if (n == '0) begin
          d <= WordBits'(1);
        end else if (d[WordBits-1]) begin
          n  <= WordBits'(-n);
          d  <= WordBits'(-d);
          ov <= ov | (n == {1'b1, {(WordBits-1){1'b0}}}) |
                (d == {1'b1, {(WordBits-1){1'b0}}});
        end
      end
      default: begin
      end
    endcase
    if (ctl.cmd == CMD_LOAD) begin
      x <= '0;
      y <= '0;
    end
    if (ctl.cmd == CMD_QN_START) begin
      g <= x;
    end
  end

  assign sts.y_zero   = (y == '0);
  assign sts.g_zero   = (x == '0);
  assign sts.div_done = div_done;
  assign sts.mul_path = (mode == OP_ADD) || (mode == OP_SUB) ||
                        (mode == OP_MUL) || (mode == OP_DIV);

  assign out_item.res_num  = n;
  assign out_item.res_den  = d;
  assign out_item.overflow = ov;

endmodule

### rtl/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences products, the Euclid loop, the two reductions and the sign fix.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic [2:0] mode,
  input  rau_sts_t sts,
  output rau_ctl_t ctl,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;
  logic   mul3;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mul3  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        mul3 <= (mode == OP_ADD) || (mode == OP_SUB);
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl.cmd    = CMD_NONE;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.cmd    = CMD_LOAD;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (sts.mul_path) begin
          ctl.cmd    = CMD_MUL1;
          state_next = ST_MUL2;
        end else begin
          state_next = ST_GCD_CHK;
        end
      end
      ST_MUL2: begin
        ctl.cmd    = CMD_MUL2;
        state_next = mul3 ? ST_MUL3 : ST_GCD_CHK;
      end
      ST_MUL3: begin
        ctl.cmd    = CMD_MUL3;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        ctl.cmd    = CMD_SUM;
        state_next = ST_GCD_CHK;
      end
      ST_GCD_CHK: begin
        ctl.cmd    = CMD_GCD_START;
        state_next = ST_GCD_DIV;
      end
      ST_GCD_DIV: begin
        if (sts.y_zero) begin
          state_next = sts.g_zero ? ST_FIX : ST_QN_DIV;
        end else begin
          ctl.cmd    = CMD_GCD_START;
          state_next = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (sts.div_done) begin
          ctl.cmd    = CMD_GCD_STEP;
          state_next = ST_GCD_DIV;
        end
      end
      ST_QN_DIV: begin
        ctl.cmd    = CMD_QN_START;
        state_next = ST_QN_WAIT;
      end
      ST_QN_WAIT: begin
        if (sts.div_done) begin
          ctl.cmd    = CMD_QN_TAKE;
          state_next = ST_QD_DIV;
        end
      end
      ST_QD_DIV: begin
        ctl.cmd    = CMD_QD_START;
        state_next = ST_QD_WAIT;
      end
      ST_QD_WAIT: begin
        if (sts.div_done) begin
          ctl.cmd    = CMD_QD_TAKE;
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        ctl.cmd    = CMD_FIX;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides, negates or normalizes fractions and
// returns the result in lowest terms with a wrap flag.
//
// Usage: drive cmd with an operation and two fractions and raise start while
// busy is low; that edge is the input transfer. busy then stays high until
// the result has been shown. The result appears on result for one cycle with
// valid high; the receiver cannot stall it.
// Sequence: up to three products and a sum, then Euclid on a shared
// radix-2 divider with one division per remainder step, then, unless the
// gcd is zero, two exact divisions, a sign fix and the result cycle. The
// worst case needs about 46 Euclid steps. A new transfer can be taken in
// the cycle after the result cycle; one item is in flight at a time.
// Reset clears the controller to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rau_in_t  cmd,
  output logic     busy,
  output logic     valid,
  output rau_out_t result
);

  rau_ctl_t ctl;
  rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (cmd.mode),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (valid)
  );

  rau_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (cmd),
    .ctl      (ctl),
    .sts      (sts),
    .out_item (result)
  );

endmodule

### verif/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction operations through the start/busy command port, predicts
// each reduced result with a behavioural model and checks every field of
// the single-cycle result strobe against it, in order.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  rau_in_t  cmd;
  logic     busy;
  logic     valid;
  rau_out_t result;

  rational_arithmetic_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .valid  (valid),
    .result (result)
  );

  rau_in_t  pending_q[$];
  rau_out_t fraction_q[$];
  int       mismatches;
  int       idle_pct;
  bit       stimulus_done;
  bit       hold_off;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint wrap32(longint v);
    logic [31:0] w;
    w = v[31:0];
    return longint'($signed(w));
  endfunction

  function automatic longint fit32(longint v, ref bit ov);
    longint w;
    w = wrap32(v);
    if (w != v) ov = 1'b1;
    return w;
  endfunction

  function automatic rau_out_t reduce_fraction(rau_in_t c);
    rau_out_t r;
    longint an, ad, bn, bd, n, d, p, q, x, y, t;
    bit ov;
    an = longint'(c.a_num);
    ad = longint'(c.a_den);
    bn = longint'(c.b_num);
    bd = longint'(c.b_den);
    ov = 1'b0;
    case (c.mode)
      OP_ADD, OP_SUB: begin
        p = fit32(an * bd, ov);
        q = fit32(ad * bn, ov);
        n = fit32((c.mode == OP_ADD) ? p + q : p - q, ov);
        d = fit32(ad * bd, ov);
      end
      OP_MUL: begin
        n = fit32(an * bn, ov);
        d = fit32(ad * bd, ov);
      end
      OP_DIV: begin
        n = fit32(an * bd, ov);
        d = fit32(ad * bn, ov);
      end
      OP_NEG: begin
        n = fit32(-an, ov);
        d = ad;
      end
      default: begin
        n = an;
        d = ad;
      end
    endcase
    x = n;
    y = d;
    while (y != 0) begin
      t = (y == -1) ? 0 : x % y;
      x = y;
      y = t;
    end
    if (x != 0) begin
      n = fit32(n / x, ov);
      d = fit32(d / x, ov);
    end
    if (n == 0) d = 1;
    else if (d < 0) begin
      n = fit32(-n, ov);
      d = fit32(-d, ov);
    end
    r.res_num  = n[31:0];
    r.res_den  = d[31:0];
    r.overflow = ov;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom;
      5, 6: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 131070)) - 65535);
    endcase
  endfunction

  task automatic push_op(logic [2:0] m, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd);
    rau_in_t c;
    c.mode  = m;
    c.a_num = an;
    c.a_den = ad;
    c.b_num = bn;
    c.b_den = bd;
    pending_q.push_back(c);
  endtask

  // driver: present at falling edge, transfer on rising edge with busy low
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // the transfer took place earlier and busy is low again, so the item is done
      start <= 1'b0;
    end else if (!start && pending_q.size() > 0 && !hold_off &&
                 $urandom_range(0, 99) >= idle_pct) begin
      cmd   <= pending_q[0];
      fraction_q.push_back(reduce_fraction(pending_q[0]));
      void'(pending_q.pop_front());
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rau_out_t e;
    if (!rst && valid) begin
      if (fraction_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        e = fraction_q.pop_front();
        if (result.res_num !== e.res_num || result.res_den !== e.res_den ||
            result.overflow !== e.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d ov %b, got %0d/%0d ov %b",
                     e.res_num, e.res_den, e.overflow,
                     result.res_num, result.res_den, result.overflow);
        end
      end
    end
  end

  initial begin
    #500_000_000;
    $display("rational_arithmetic_unit verification failed");
    $finish;
  end

  initial begin
    int m;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    mismatches = 0;
    idle_pct = 0;
    hold_off = 1'b0;
    stimulus_done = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every operation, extremes, zero denominators, -1 cases
    push_op(OP_ADD, 1, 2, 1, 3);
    push_op(OP_SUB, 1, 2, 1, 2);
    push_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 3);
    push_op(OP_DIV, 6, 4, -9, 2);
    push_op(OP_NEG, 32'h8000_0000, 1, 0, 0);
    push_op(OP_NEG, 32'h8000_0000, -1, 0, 0);
    push_op(OP_NRM, 32'h8000_0000, -1, 5, 5);
    push_op(OP_NRM, 12, -18, 0, 0);
    push_op(OP_NRM, 7, 0, 0, 0);
    push_op(OP_NRM, -7, 0, 0, 0);
    push_op(OP_NRM, 0, 0, 0, 0);
    push_op(OP_NRM, 0, -5, 0, 0);
    push_op(3'd6, 10, -4, 1, 1);
    push_op(3'd7, -3, -9, 1, 1);
    push_op(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    push_op(OP_SUB, 32'h7fff_ffff, 1, 32'h8000_0000, 1);
    push_op(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_op(OP_DIV, 32'h8000_0000, 1, 32'hffff_ffff, 1);
    push_op(OP_DIV, 5, 1, 0, 1);
    push_op(OP_MUL, 0, 32'h7fff_ffff, 3, 32'h8000_0000);
    push_op(OP_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
    push_op(OP_NRM, 1836311903, 1134903170, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 72 : (ph == 3) ? 15 : 0;
      for (int i = 0; i < 490; i++) begin
        m = $urandom_range(0, 7);
        push_op(m[2:0], pick_word(), pick_word(), pick_word(), pick_word());
      end
      wait (pending_q.size() == 0);
      if (ph == 1) begin
        // hold the sender until everything outstanding has returned
        hold_off = 1'b1;
        wait (fraction_q.size() == 0);
        hold_off = 1'b0;
      end
    end
    wait (pending_q.size() == 0 && !start);
    wait (fraction_q.size() == 0);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && fraction_q.size() == 0)
      $display("rational_arithmetic_unit verification clean");
    else
      $display("rational_arithmetic_unit verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
verif/tb_rational_arithmetic_unit.sv
